// ----- sv/assert_macros.svh -----
// Assertion helpers shared by the RTL files of the sine core.
// ASSERT_CLK checks a property at every rising clock edge outside reset.
// ASSERT_NORST checks a property at every rising clock edge, reset included.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define ASSERT_NORST(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

// ----- sv/tss_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

	localparam int ANGLE_W  = 32;
	localparam int RESULT_W = 32;
	localparam int THR_W    = 31;

	localparam logic [THR_W-1:0] THR_RESET = 31'd10737;

	localparam int MAX_TERMS_DEF        = 16;
	localparam int RESULT_FRAC_BITS_DEF = 30;

	// 2*pi in Q8.24.
	localparam logic [ANGLE_W-1:0] TWO_PI_Q24 = 32'd105414357;
	// The quotient of a magnitude of at most 2^31 by 2*pi stays below 2^5.
	localparam int RED_STEPS = 5;
	localparam int RED_K_W   = 3;

	localparam int XM_W   = 27;  // reduced angle magnitude, Q.24
	localparam int X2_W   = 54;  // squared magnitude, Q.48
	localparam int MAG_W  = 40;  // term magnitude, Q.32
	localparam int SUM_W  = 44;  // signed sum, Q.32
	localparam int MUL_W  = 32;
	localparam int PROD_W = 64;
	localparam int ACC_W  = 64;

	// Shared multiply-accumulate operations.
	localparam logic [2:0] MAC_NOP     = 3'd0;
	localparam logic [2:0] MAC_LOAD    = 3'd1;
	localparam logic [2:0] MAC_ADD_SHR = 3'd2;
	localparam logic [2:0] MAC_ADD     = 3'd3;
	localparam logic [2:0] MAC_ADD_HI  = 3'd4;

	typedef struct packed {
		logic [2:0]       op;
		logic [MUL_W-1:0] a;
		logic [MUL_W-1:0] b;
	} mac_req_t;

	// Reciprocals of 2n(2n+1) in Q0.32, rounded to nearest, entry n-1.
	localparam int RECIP_W     = 32;
	localparam int RECIP_DEPTH = 32;
	localparam int RECIP_IDX_W = 5;
	localparam logic [63:0] TWO_32 = 64'h1_0000_0000;

	localparam logic [RECIP_W-1:0] RECIP_TAB [RECIP_DEPTH] = '{
		32'((TWO_32 + 64'd3) / 64'd6),
		32'((TWO_32 + 64'd10) / 64'd20),
		32'((TWO_32 + 64'd21) / 64'd42),
		32'((TWO_32 + 64'd36) / 64'd72),
		32'((TWO_32 + 64'd55) / 64'd110),
		32'((TWO_32 + 64'd78) / 64'd156),
		32'((TWO_32 + 64'd105) / 64'd210),
		32'((TWO_32 + 64'd136) / 64'd272),
		32'((TWO_32 + 64'd171) / 64'd342),
		32'((TWO_32 + 64'd210) / 64'd420),
		32'((TWO_32 + 64'd253) / 64'd506),
		32'((TWO_32 + 64'd300) / 64'd600),
		32'((TWO_32 + 64'd351) / 64'd702),
		32'((TWO_32 + 64'd406) / 64'd812),
		32'((TWO_32 + 64'd465) / 64'd930),
		32'((TWO_32 + 64'd528) / 64'd1056),
		32'((TWO_32 + 64'd595) / 64'd1190),
		32'((TWO_32 + 64'd666) / 64'd1332),
		32'((TWO_32 + 64'd741) / 64'd1482),
		32'((TWO_32 + 64'd820) / 64'd1640),
		32'((TWO_32 + 64'd903) / 64'd1806),
		32'((TWO_32 + 64'd990) / 64'd1980),
		32'((TWO_32 + 64'd1081) / 64'd2162),
		32'((TWO_32 + 64'd1176) / 64'd2352),
		32'((TWO_32 + 64'd1275) / 64'd2550),
		32'((TWO_32 + 64'd1378) / 64'd2756),
		32'((TWO_32 + 64'd1485) / 64'd2970),
		32'((TWO_32 + 64'd1596) / 64'd3192),
		32'((TWO_32 + 64'd1711) / 64'd3422),
		32'((TWO_32 + 64'd1830) / 64'd3660),
		32'((TWO_32 + 64'd1953) / 64'd3906),
		32'((TWO_32 + 64'd2080) / 64'd4160)
	};

endpackage

`default_nettype wire

// ----- sv/tss_range_reduce.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tss_range_reduce import tss_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [ANGLE_W-1:0] mag_in,
	output logic [ANGLE_W-1:0] rem,
	output logic               done
);

	logic [ANGLE_W-1:0] rem_q;
	logic [RED_K_W-1:0] k_q;
	logic               busy_q;
	logic               done_q;
	logic [ANGLE_W-1:0] sub_val;

	// Restoring division: one compare and subtract of 2*pi << k per cycle.
	assign sub_val = TWO_PI_Q24 << k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			k_q    <= '0;
		end else begin
			done_q <= !start && busy_q && (k_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				k_q    <= RED_K_W'(RED_STEPS - 1);
			end else if (busy_q) begin
				if (k_q == '0) begin
					busy_q <= 1'b0;
				end else begin
					k_q <= k_q - RED_K_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= mag_in;
		end else if (busy_q && (rem_q >= sub_val)) begin
			rem_q <= rem_q - sub_val;
		end
	end

	assign rem  = rem_q;
	assign done = done_q;

	`ASSERT_CLK(a_rem_reduced, clk, arst_n, done |-> (rem_q < TWO_PI_Q24), "remainder not reduced")
	`ASSERT_NORST(a_done_rst, clk, !arst_n |=> !done_q, "done set out of reset")

endmodule

`default_nettype wire

// ----- sv/tss_mac.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tss_mac import tss_pkg::*; (
	input  logic              clk,
	input  mac_req_t          req,
	output logic [PROD_W-1:0] prod,
	output logic [ACC_W-1:0]  acc
);

	logic [PROD_W-1:0] mul_res;
	logic [PROD_W-1:0] prod_q;
	logic [ACC_W-1:0]  acc_q;

	assign mul_res = req.a * req.b;

	// The product is registered; the accumulator folds it in on the cycle after.
	always_ff @(posedge clk) begin
		prod_q <= mul_res;
		case (req.op)
			MAC_LOAD:    acc_q <= prod_q;
			MAC_ADD_SHR: acc_q <= (acc_q >> MUL_W) + prod_q;
			MAC_ADD:     acc_q <= acc_q + prod_q;
			MAC_ADD_HI:  acc_q <= acc_q + (prod_q << MUL_W);
			default:     acc_q <= acc_q;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

// ----- sv/taylor_series_sine_core.sv -----
// Sine of a signed Q8.24 angle by Taylor series, returned as signed Q2.30 (the
// fraction width follows RESULT_FRAC_BITS) with rounding half away from zero and
// saturation. The angle is first reduced by 2*pi as a truncated remainder, so its
// sign is kept. The series then adds x, -x^3/3!, x^5/5! and so on, each term built
// from the previous one with a reciprocal table, and stops after the first term
// whose magnitude is below term_threshold (Q1.30, written through the config
// channel at any time the core is idle; reset value 10737, about 1e-5). When
// MAX_TERMS terms follow x and the last one is still not below the threshold,
// term_limit_hit is set. One transaction is processed at a time: in_ready is high
// only while the core is idle. A transaction adds 1 to MAX_TERMS terms after x and
// runs through range reduction (five compare-and-subtract steps and one to hand
// the remainder over), the S_SQR and S_SQRW states to square the reduced angle,
// then states S_T0 to S_T8 per term on the single shared 32x32 multiplier, which
// forms six partial products per term, and S_FIN1 and S_FIN2 for rounding and
// saturation. The result sits in an output register, so the core takes the next
// transaction while it waits.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module taylor_series_sine_core import tss_pkg::*; #(
	parameter int MAX_TERMS        = MAX_TERMS_DEF,
	parameter int RESULT_FRAC_BITS = RESULT_FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [THR_W-1:0]           cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [ANGLE_W-1:0]  angle,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [RESULT_W-1:0] sine_value,
	output logic                       term_limit_hit
);

	localparam int NW = $clog2(MAX_TERMS + 1);
	localparam int SH = 32 - RESULT_FRAC_BITS;
	localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (SH - 1);
	localparam logic [SUM_W-1:0] SAT_NEG = SUM_W'(64'h8000_0000);
	localparam logic [SUM_W-1:0] SAT_POS = SUM_W'(64'h7FFF_FFFF);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RED  = 4'd1;
	localparam logic [3:0] S_SQR  = 4'd2;
	localparam logic [3:0] S_SQRW = 4'd3;
	localparam logic [3:0] S_T0   = 4'd4;
	localparam logic [3:0] S_T1   = 4'd5;
	localparam logic [3:0] S_T2   = 4'd6;
	localparam logic [3:0] S_T3   = 4'd7;
	localparam logic [3:0] S_T4   = 4'd8;
	localparam logic [3:0] S_T5   = 4'd9;
	localparam logic [3:0] S_T6   = 4'd10;
	localparam logic [3:0] S_T7   = 4'd11;
	localparam logic [3:0] S_T8   = 4'd12;
	localparam logic [3:0] S_FIN1 = 4'd13;
	localparam logic [3:0] S_FIN2 = 4'd14;

	logic [3:0]          state_q;
	logic [THR_W-1:0]    thr_q;
	logic [NW-1:0]       n_q;
	logic                neg_q;
	logic                tneg_q;
	logic                hit_q;
	logic [X2_W-1:0]     x2_q;
	logic [MAG_W-1:0]    mag_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUM_W-1:0]    abs_q;
	logic                sneg_q;
	logic                out_valid_q;
	logic [RESULT_W-1:0] sine_q;
	logic                hit_out_q;

	logic                   accept;
	logic [ANGLE_W-1:0]     angle_abs;
	logic [ANGLE_W-1:0]     red_rem;
	logic                   red_done;
	logic [XM_W-1:0]        xm;
	mac_req_t               mac_req;
	logic [PROD_W-1:0]      mac_prod;
	logic [ACC_W-1:0]       mac_acc;
	logic [RECIP_IDX_W-1:0] recip_idx;
	logic [RECIP_W-1:0]     recip;
	logic [MAG_W-1:0]       new_mag;
	logic [MAG_W-1:0]       thr_ext;
	logic                   below;
	logic [SUM_W-1:0]       mag_ext;
	logic [SUM_W-1:0]       first_ext;
	logic [SUM_W-1:0]       rnd;
	logic [SUM_W-1:0]       shv;
	logic [RESULT_W-1:0]    res;
	logic                   out_free;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// Magnitude of the angle; the most negative input maps to 2^31, still in 32 bits.
	assign angle_abs = angle[ANGLE_W-1] ? (ANGLE_W'(0) - angle) : angle;

	tss_range_reduce u_reduce (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.mag_in (angle_abs),
		.rem    (red_rem),
		.done   (red_done)
	);

	assign xm = red_rem[XM_W-1:0];

	assign recip_idx = RECIP_IDX_W'(n_q - NW'(1));
	assign recip     = RECIP_TAB[recip_idx];

	// Operand and accumulate selection for the shared multiplier. A term takes
	// mag * x^2 >> 48 from four partial products, then that times the reciprocal
	// >> 32 from two more.
	always_comb begin
		mac_req.op = MAC_NOP;
		mac_req.a  = '0;
		mac_req.b  = '0;
		case (state_q)
			S_SQR: begin
				mac_req.a = MUL_W'(xm);
				mac_req.b = MUL_W'(xm);
			end
			S_T0: begin
				mac_req.a = mag_q[MUL_W-1:0];
				mac_req.b = x2_q[MUL_W-1:0];
			end
			S_T1: begin
				mac_req.op = MAC_LOAD;
				mac_req.a  = mag_q[MUL_W-1:0];
				mac_req.b  = MUL_W'(x2_q[X2_W-1:MUL_W]);
			end
			S_T2: begin
				mac_req.op = MAC_ADD_SHR;
				mac_req.a  = MUL_W'(mag_q[MAG_W-1:MUL_W]);
				mac_req.b  = x2_q[MUL_W-1:0];
			end
			S_T3: begin
				mac_req.op = MAC_ADD;
				mac_req.a  = MUL_W'(mag_q[MAG_W-1:MUL_W]);
				mac_req.b  = MUL_W'(x2_q[X2_W-1:MUL_W]);
			end
			S_T4: begin
				mac_req.op = MAC_ADD_HI;
			end
			S_T5: begin
				mac_req.a = mac_acc[47:16];
				mac_req.b = recip;
			end
			S_T6: begin
				mac_req.op = MAC_LOAD;
				mac_req.a  = MUL_W'(mac_acc[61:48]);
				mac_req.b  = recip;
			end
			S_T7: begin
				mac_req.op = MAC_ADD_SHR;
			end
			default: begin
				mac_req.op = MAC_NOP;
			end
		endcase
	end

	tss_mac u_mac (
		.clk  (clk),
		.req  (mac_req),
		.prod (mac_prod),
		.acc  (mac_acc)
	);

	// The new term magnitude and the stop test against the threshold in Q.32.
	assign new_mag   = mac_acc[MAG_W-1:0];
	assign thr_ext   = MAG_W'({thr_q, 2'b00});
	assign below     = (new_mag < thr_ext);
	assign mag_ext   = SUM_W'(new_mag);
	assign first_ext = SUM_W'({xm, 8'b0});

	// Rounding half away from zero on the magnitude, then saturation.
	assign rnd = abs_q + HALF;
	assign shv = rnd >> SH;
	always_comb begin
		if (sneg_q) begin
			if (shv > SAT_NEG) begin
				res = RESULT_W'(SAT_NEG);
			end else begin
				res = RESULT_W'(SUM_W'(0) - shv);
			end
		end else begin
			if (shv > SAT_POS) begin
				res = RESULT_W'(SAT_POS);
			end else begin
				res = RESULT_W'(shv);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			thr_q       <= THR_RESET;
			n_q         <= NW'(1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			// A result leaving in the same cycle as a new one arrives keeps valid high.
			if (out_valid_q && out_ready && (state_q != S_FIN2)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RED;
					end
				end
				S_RED: begin
					if (red_done) begin
						state_q <= S_SQR;
					end
				end
				S_SQR:  state_q <= S_SQRW;
				S_SQRW: begin
					n_q     <= NW'(1);
					state_q <= S_T0;
				end
				S_T0: state_q <= S_T1;
				S_T1: state_q <= S_T2;
				S_T2: state_q <= S_T3;
				S_T3: state_q <= S_T4;
				S_T4: state_q <= S_T5;
				S_T5: state_q <= S_T6;
				S_T6: state_q <= S_T7;
				S_T7: state_q <= S_T8;
				S_T8: begin
					if (below || (n_q == NW'(MAX_TERMS))) begin
						state_q <= S_FIN1;
					end else begin
						n_q     <= n_q + NW'(1);
						state_q <= S_T0;
					end
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers of the sum and the term.
	always_ff @(posedge clk) begin
		if (accept) begin
			neg_q <= angle[ANGLE_W-1];
		end
		case (state_q)
			S_SQRW: begin
				x2_q   <= mac_prod[X2_W-1:0];
				mag_q  <= MAG_W'({xm, 8'b0});
				tneg_q <= neg_q;
				sum_q  <= neg_q ? (SUM_W'(0) - first_ext) : first_ext;
			end
			S_T8: begin
				mag_q  <= new_mag;
				tneg_q <= !tneg_q;
				sum_q  <= tneg_q ? (sum_q + mag_ext) : (sum_q - mag_ext);
				hit_q  <= !below;
			end
			S_FIN1: begin
				sneg_q <= sum_q[SUM_W-1];
				abs_q  <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
			end
			S_FIN2: begin
				if (out_free) begin
					sine_q    <= res;
					hit_out_q <= hit_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign sine_value     = sine_q;
	assign term_limit_hit = hit_out_q;

	`ASSERT_CLK(a_busy_after_accept, clk, arst_n, accept |=> !in_ready, "ready after accept")
	`ASSERT_CLK(a_term_count, clk, arst_n, n_q <= NW'(MAX_TERMS), "term count overrun")
	`ASSERT_CLK(a_hit_full, clk, arst_n, $rose(out_valid_q) && hit_out_q |-> n_q == NW'(MAX_TERMS), "limit flag without full term count")
	`ASSERT_NORST(a_out_rst, clk, !arst_n |=> !out_valid_q, "output valid out of reset")

endmodule

`default_nettype wire

// ----- sim/tb_taylor_series_sine_core.sv -----
`timescale 1ns / 1ps

module tb_taylor_series_sine_core;
	import tss_pkg::*;

	// Block configuration used for both the instance and the predictor.
	localparam int N_TERMS   = 16;
	localparam int FRAC_BITS = 30;
	localparam int SUM_FRAC  = 32;

	// 2*pi in Q8.24, and a few handy angles derived from it.
	localparam longint TWO_PI_FIX  = 105414357;
	localparam longint PI_FIX      = 52707179;
	localparam longint HALF_PI_FIX = 26353589;

	localparam logic [THR_W-1:0] THR_AFTER_RESET = 31'd10737;
	localparam logic [THR_W-1:0] THR_ONE_UNIT    = 31'd1;
	localparam logic [THR_W-1:0] THR_UNITY       = 31'h4000_0000;
	localparam logic [THR_W-1:0] THR_ALL_ONES    = 31'h7FFF_FFFF;
	localparam logic [THR_W-1:0] THR_ZERO        = 31'd0;

	// The watchdog limit leaves a wide margin above the worst case, stalls included.
	localparam int unsigned CYCLE_LIMIT  = 1_500_000;
	localparam int          SETTLE_TICKS = 8;
	localparam int          TAIL_TICKS   = 200;
	localparam int          RANDOM_ITEMS = 380;
	localparam int          MAX_PRINTED  = 100;

	typedef struct packed {
		logic signed [RESULT_W-1:0] sine;
		logic                       limit_hit;
	} sine_result_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       cfg_valid      = 1'b0;
	logic                       cfg_ready;
	logic [THR_W-1:0]           cfg_data       = '0;
	logic                       in_valid       = 1'b0;
	logic                       in_ready;
	logic signed [ANGLE_W-1:0]  angle          = '0;
	logic                       out_valid;
	logic                       out_ready      = 1'b0;
	logic signed [RESULT_W-1:0] sine_value;
	logic                       term_limit_hit;

	// Our copy of the threshold register and the sines still owed by the block.
	logic [THR_W-1:0] model_threshold = THR_AFTER_RESET;
	sine_result_t     expected_sines[$];
	sine_result_t     oldest_sine;

	int          send_idle_pct  = 0;
	int          recv_stall_pct = 0;
	int          error_count    = 0;
	int          angles_sent    = 0;
	int          sines_checked  = 0;
	int          threshold_writes = 0;
	int unsigned cycle_count    = 0;

	taylor_series_sine_core #(
		.MAX_TERMS       (N_TERMS),
		.RESULT_FRAC_BITS(FRAC_BITS)
	) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.angle         (angle),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sine_value    (sine_value),
		.term_limit_hit(term_limit_hit)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// (a * b) >> s with the full 128-bit product, kept to 64 bits.
	function automatic bit [63:0] scaled_product(bit [63:0] a, bit [63:0] b, int unsigned s);
		bit [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return 64'(p >> s);
	endfunction

	// Bit-exact sine of one angle under the given threshold. The angle is reduced
	// by 2*pi keeping its sign, terms are built from the previous one with a
	// rounded reciprocal of 2n(2n+1), and the sum stops right after the first
	// term that falls below the threshold.
	function automatic sine_result_t predict_sine(logic signed [ANGLE_W-1:0] a,
			logic [THR_W-1:0] thr_reg);
		longint       r;
		longint       sum;
		bit           negative;
		bit           term_neg;
		bit           done;
		bit [63:0]    xm;
		bit [63:0]    x2;
		bit [63:0]    mag;
		bit [63:0]    thr;
		bit [63:0]    am;
		bit [63:0]    d;
		bit [63:0]    recip;
		int           n;
		sine_result_t res;

		r        = longint'(a) % TWO_PI_FIX;
		negative = (r < 0);
		xm       = negative ? 64'(-r) : 64'(r);
		x2       = xm * xm;
		mag      = xm << (SUM_FRAC - 24);
		term_neg = negative;
		sum      = negative ? -longint'(mag) : longint'(mag);
		thr      = 64'(thr_reg) << (SUM_FRAC - 30);
		done     = 1'b0;

		for (n = 1; n <= N_TERMS && !done; n++) begin
			d        = 64'(2 * n) * 64'(2 * n + 1);
			recip    = ((64'd1 << 32) + d / 2) / d;
			mag      = scaled_product(scaled_product(mag, x2, 48), recip, 32);
			term_neg = !term_neg;
			sum      = sum + (term_neg ? -longint'(mag) : longint'(mag));
			if (mag < thr)
				done = 1'b1;
		end
		res.limit_hit = !done;

		// Round half away from zero on the magnitude, then saturate.
		am = (sum < 0) ? 64'(-sum) : 64'(sum);
		am = (am + (64'd1 << (SUM_FRAC - FRAC_BITS - 1))) >> (SUM_FRAC - FRAC_BITS);
		if (sum < 0) begin
			if (am > 64'h8000_0000)
				am = 64'h8000_0000;
			res.sine = RESULT_W'(64'd0 - am);
		end else begin
			if (am > 64'h7FFF_FFFF)
				am = 64'h7FFF_FFFF;
			res.sine = RESULT_W'(am);
		end
		return res;
	endfunction

	// Angles drawn from four pools: any 32-bit pattern, the principal range,
	// just around multiples of 2*pi across the whole input range, and small angles.
	function automatic logic signed [ANGLE_W-1:0] random_angle();
		longint                    k;
		longint                    delta;
		logic signed [ANGLE_W-1:0] a;

		case ($urandom_range(3))
			0: a = $urandom();
			1: a = ANGLE_W'(longint'($urandom_range(2 * TWO_PI_FIX)) - TWO_PI_FIX);
			2: begin
				k     = longint'($urandom_range(40)) - 20;
				delta = longint'($urandom_range(2000)) - 1000;
				a     = ANGLE_W'(k * TWO_PI_FIX + delta);
			end
			default: begin
				a = ANGLE_W'($urandom_range(1 << 25));
				if ($urandom_range(1))
					a = -a;
			end
		endcase
		return a;
	endfunction

	// Thresholds spread roughly evenly over their bit lengths, with the edge
	// values and the reset value mixed in.
	function automatic logic [THR_W-1:0] random_threshold();
		logic [THR_W-1:0] t;

		case ($urandom_range(7))
			0: t = THR_ZERO;
			1: t = THR_ALL_ONES;
			2: t = THR_UNITY;
			3: t = THR_AFTER_RESET;
			4: t = THR_ONE_UNIT;
			default: t = THR_W'($urandom()) >> $urandom_range(THR_W - 1);
		endcase
		return t;
	endfunction

	task automatic report_mismatch(input string what);
		if (error_count < MAX_PRINTED)
			$display("[%0t] error: %s", $time, what);
		error_count++;
	endtask

	// Offers one angle and waits for the block to take it. Valid is only dropped
	// while the sender is idling, so back-to-back angles keep it high.
	task automatic send_angle(input logic signed [ANGLE_W-1:0] a);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		angle    <= a;
		do
			@(posedge clk);
		while (!in_ready);
		expected_sines.push_back(predict_sine(a, model_threshold));
		angles_sent++;
	endtask

	// Drops valid and waits until every owed sine has come back.
	task automatic wait_idle(input int extra_ticks);
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_sines.size() != 0)
			@(negedge clk);
		repeat (extra_ticks) @(negedge clk);
	endtask

	// Threshold writes only happen with the block idle.
	task automatic write_threshold(input logic [THR_W-1:0] value);
		wait_idle(SETTLE_TICKS);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		model_threshold = value;
		threshold_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reset threshold: zero, both input extremes, tiny values, exact and almost
	// exact multiples of 2*pi, and pi and pi/2 of both signs.
	task automatic test_directed_angles();
		logic signed [ANGLE_W-1:0] corner_angles[13];

		corner_angles = '{
			32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0000_0001,
			ANGLE_W'(TWO_PI_FIX), ANGLE_W'(-TWO_PI_FIX),
			ANGLE_W'(TWO_PI_FIX - 1), ANGLE_W'(1 - TWO_PI_FIX),
			ANGLE_W'(PI_FIX), ANGLE_W'(-PI_FIX),
			ANGLE_W'(HALF_PI_FIX), ANGLE_W'(-HALF_PI_FIX)
		};
		foreach (corner_angles[i])
			send_angle(corner_angles[i]);
	endtask

	// A zero threshold never stops the series, so the term cap must be flagged, even
	// for a zero angle. The largest thresholds stop 0 and pi/2 at the first term.
	task automatic test_threshold_extremes();
		logic [THR_W-1:0]          edge_thresholds[4];
		logic signed [ANGLE_W-1:0] probe_angles[3];

		edge_thresholds = '{THR_ZERO, THR_ONE_UNIT, THR_UNITY, THR_ALL_ONES};
		probe_angles    = '{32'h0000_0000, ANGLE_W'(HALF_PI_FIX), 32'd100000000};
		foreach (edge_thresholds[t]) begin
			write_threshold(edge_thresholds[t]);
			foreach (probe_angles[i])
				send_angle(probe_angles[i]);
		end
	endtask

	// Random angles under one pacing mode, in four blocks with a fresh threshold.
	task automatic test_random_angles(input int idle_pct, input int stall_pct,
			input int count);
		wait_idle(SETTLE_TICKS);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		for (int blk = 0; blk < 4; blk++) begin
			write_threshold(random_threshold());
			repeat (count / 4)
				send_angle(random_angle());
		end
	endtask

	// The receiver decides once per cycle whether to stall.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Every sine the block hands over is matched against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_sines.size() == 0) begin
				report_mismatch($sformatf("unexpected sine 0x%08h, flag %0b",
					sine_value, term_limit_hit));
			end else begin
				oldest_sine = expected_sines.pop_front();
				sines_checked++;
				if (sine_value !== oldest_sine.sine)
					report_mismatch($sformatf("sine_value 0x%08h, wanted 0x%08h",
						sine_value, oldest_sine.sine));
				if (term_limit_hit !== oldest_sine.limit_hit)
					report_mismatch($sformatf("term_limit_hit %0b, wanted %0b",
						term_limit_hit, oldest_sine.limit_hit));
			end
		end
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d sines still owed",
				cycle_count, expected_sines.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_angles();
		test_threshold_extremes();
		test_random_angles(0, 0, RANDOM_ITEMS);
		test_random_angles(64, 0, RANDOM_ITEMS);
		test_random_angles(0, 64, RANDOM_ITEMS);
		test_random_angles(25, 25, RANDOM_ITEMS);

		// Catch any stray result the block might still produce.
		wait_idle(TAIL_TICKS);

		$display("%0d angles sent and %0d sines compared, %0d threshold writes,",
			angles_sent, sines_checked, threshold_writes);
		$display("four pacing modes with sender gaps and receiver stalls; %0d errors",
			error_count);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/tss_pkg.sv
sv/tss_range_reduce.sv
sv/tss_mac.sv
sv/taylor_series_sine_core.sv
sim/tb_taylor_series_sine_core.sv
